// ===== src/tss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spectrum sampler package
// Shared constants, request, status and mode codes, and the state type.
// ----------------------------------------------------------------------------
package tss_pkg;

  localparam int unsigned TableDepth     = 256;
  localparam int unsigned RandomBits     = 24;
  localparam int unsigned WavelengthBits = 20;
  localparam int unsigned WeightBits     = 24;
  localparam int unsigned EnergyBits     = 27;
  localparam logic [26:0] EnergyConst    = 27'd123984187;
  localparam logic [23:0] WeightMax      = 24'hFFFFFF;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_DRAW  = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_NOP   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_ORDER = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    MODE_FIXED  = 2'd0,
    MODE_HIST   = 2'd1,
    MODE_INTERP = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_READ,
    S_ADJ,
    S_DIV,
    S_OUT
  } state_e;

endpackage

// ===== src/tss_div_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spectrum sampler divider cell
// One restoring division step; cells are chained, each registering its
// partial remainder and handing it to the next cell every cycle.
// ----------------------------------------------------------------------------
module tss_div_cell #(
  parameter int unsigned WavelengthBits = tss_pkg::WavelengthBits,
  parameter int unsigned Shift          = 0
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic [26:0]               rem_i,
  input  logic [26:0]               quo_i,
  input  logic [WavelengthBits-1:0] div_i,
  output logic                      valid_o,
  output logic [26:0]               rem_o,
  output logic [26:0]               quo_o,
  output logic [WavelengthBits-1:0] div_o
);

  logic [WavelengthBits+26:0] trial;
  logic                       fits;

  always_comb begin
    trial = {{(WavelengthBits){1'b0}}, rem_i};
    fits  = ((trial >> Shift) >= {{27{1'b0}}, div_i});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    div_o <= div_i;
    if (fits) begin
      rem_o <= 27'(trial - ({{27{1'b0}}, div_i} << Shift));
      quo_o <= quo_i | (27'd1 << Shift);
    end else begin
      rem_o <= rem_i;
      quo_o <= quo_i;
    end
  end

endmodule

// ===== src/tss_div_chain.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spectrum sampler divider chain
// A row of 27 division cells computing the photon energy quotient.
// ----------------------------------------------------------------------------
module tss_div_chain #(
  parameter int unsigned WavelengthBits = tss_pkg::WavelengthBits
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [WavelengthBits-1:0] wl_i,
  output logic                      done_o,
  output logic [26:0]               quo_o
);

  localparam int unsigned NCells = 27;

  logic                      v   [NCells+1];
  logic [26:0]               rem [NCells+1];
  logic [26:0]               quo [NCells+1];
  logic [WavelengthBits-1:0] dv  [NCells+1];

  assign v[0]   = start_i && (wl_i != '0);
  assign rem[0] = tss_pkg::EnergyConst;
  assign quo[0] = '0;
  assign dv[0]  = wl_i;

  for (genvar k = 0; k < NCells; k++) begin : g_cell
    tss_div_cell #(
      .WavelengthBits(WavelengthBits),
      .Shift         (NCells - 1 - k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(v[k]),
      .rem_i  (rem[k]),
      .quo_i  (quo[k]),
      .div_i  (dv[k]),
      .valid_o(v[k+1]),
      .rem_o  (rem[k+1]),
      .quo_o  (quo[k+1]),
      .div_o  (dv[k+1])
    );
  end

  assign done_o = v[NCells];
  assign quo_o  = quo[NCells];

endmodule

// ===== src/tabulated_spectrum_sampler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tabulated spectrum sampler
// Draws wavelengths from a loaded table by inverse-transform sampling.
// ----------------------------------------------------------------------------
// Usage: requests arrive as beats on the in_* channel (valid/stall); each
// beat yields exactly one result beat on the out_* channel. A load appends a
// wavelength and weight, a clear empties the table, a draw returns a sampled
// wavelength, its photon energy and the chosen entry index.
// Loads, clears and error cases go straight to the output state, which
// registers the result and frees the input together. A draw runs a binary
// search of ceil(log2(entries)) probes, each waiting for the table memory
// read, plus a closing step, then fetches the entry and its neighbor,
// applies the adjustment, passes through the row of divider cells unless
// the wavelength is zero, and ends in the output state. Items are processed
// one at a time; input stall is high while an item is in flight. The result
// sits in an output register; while the receiver stalls it holds, and the
// next input beat is still taken once the previous item is finished. Reset
// empties the table, sets sample_mode to histogram and bin_width to zero.
// Table memories need no clearing: only loaded entries are read.
// sample_mode and bin_width are written through the APB port; the user must
// write them only while idle, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
module tabulated_spectrum_sampler #(
  parameter int unsigned TableDepth     = tss_pkg::TableDepth,
  parameter int unsigned RandomBits     = tss_pkg::RandomBits,
  parameter int unsigned WavelengthBits = tss_pkg::WavelengthBits
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                req_type_i,
  input  logic [WavelengthBits-1:0] wavelength_in_i,
  input  logic [15:0]               weight_in_i,
  input  logic [RandomBits-1:0]     uniform_select_i,
  input  logic [RandomBits-1:0]     uniform_offset_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [1:0]                status_o,
  output logic [WavelengthBits-1:0] wavelength_out_o,
  output logic [26:0]               energy_out_o,
  output logic [7:0]                bin_index_o
);

  localparam int unsigned IdxBits = $clog2(TableDepth);
  localparam int unsigned CntBits = IdxBits + 1;
  localparam int unsigned WB      = tss_pkg::WeightBits;

  // Configuration registers.
  logic [1:0]  mode_q;
  logic [19:0] binw_q;

  assign pready = 1'b1;
  always_comb begin
    case (paddr[2])
      1'b0:    prdata = {30'd0, mode_q};
      default: prdata = {12'd0, binw_q};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= tss_pkg::MODE_HIST;
      binw_q <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == 1'b0) begin
        mode_q <= pwdata[1:0];
      end else begin
        binw_q <= pwdata[19:0];
      end
    end
  end

  // Table memories.
  logic [WB-1:0]             rw_mem [TableDepth];
  logic [WavelengthBits-1:0] wl_mem [TableDepth];
  logic [WB-1:0]             rw_rd_q;
  logic [WavelengthBits-1:0] wl_rd_q;
  logic [IdxBits-1:0]        rd_addr;
  logic                      mem_we;
  logic [IdxBits-1:0]        wr_addr;
  logic [WB-1:0]             wr_sum;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      rw_mem[wr_addr] <= wr_sum;
      wl_mem[wr_addr] <= wavelength_in_i;
    end
    rw_rd_q <= rw_mem[rd_addr];
    wl_rd_q <= wl_mem[rd_addr];
  end

  // Control state.
  tss_pkg::state_e state_q, state_d;
  logic [CntBits-1:0]        count_q, count_d;
  logic [WB-1:0]             total_q, total_d;
  logic [WavelengthBits-1:0] last_wl_q, last_wl_d;
  logic [CntBits-1:0]        lo_q, lo_d, hi_q, hi_d;
  logic                      phase_q, phase_d;
  logic [WB-1:0]             target_q, target_d;
  logic [RandomBits-1:0]     u2_q, u2_d;
  logic [WavelengthBits-1:0] w_q, w_d;
  logic [1:0]                st_q, st_d;
  logic [WavelengthBits-1:0] wo_q, wo_d;
  logic [26:0]               en_q, en_d;
  logic [7:0]                bi_q, bi_d;
  logic                      ov_q, ov_d;
  logic                      div_start;
  logic                      div_done;
  logic [26:0]               div_quo;

  logic [WB+RandomBits-1:0]  prod;
  logic [WB:0]               sum_ext;
  logic [CntBits-1:0]        mid;
  logic [CntBits-1:0]        last_idx;
  logic [CntBits-1:0]        nx_idx;
  logic [RandomBits+21:0]    hx, hy;
  logic [RandomBits+21:0]    hd;
  logic [RandomBits+21:0]    hdn;
  logic [WavelengthBits:0]   wsum;
  logic [WavelengthBits-1:0] diff;
  logic [WavelengthBits+RandomBits-1:0] iprod;
  logic                      accept;

  assign accept   = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != tss_pkg::S_IDLE);
  assign prod     = {{RandomBits{1'b0}}, total_q} * {{WB{1'b0}}, uniform_select_i};
  assign sum_ext  = {1'b0, total_q} + {{(WB-15){1'b0}}, weight_in_i};
  assign wr_sum   = sum_ext[WB] ? tss_pkg::WeightMax : sum_ext[WB-1:0];
  assign wr_addr  = count_q[IdxBits-1:0];
  assign mid      = CntBits'((lo_q + hi_q) >> 1);
  assign last_idx = count_q - 1'b1;

  always_comb begin
    state_d = state_q; count_d = count_q; total_d = total_q;
    last_wl_d = last_wl_q; lo_d = lo_q; hi_d = hi_q; phase_d = phase_q;
    target_d = target_q; u2_d = u2_q; w_d = w_q; st_d = st_q; wo_d = wo_q;
    en_d = en_q; bi_d = bi_q; ov_d = ov_q;
    mem_we = 1'b0; div_start = 1'b0;
    rd_addr = mid[IdxBits-1:0];
    nx_idx  = (lo_q < last_idx) ? CntBits'(lo_q + 1'b1) : lo_q;
    hx = '0; hy = '0; hd = '0; hdn = '0; wsum = '0; diff = '0; iprod = '0;
    if (ov_q && !out_stall_i) ov_d = 1'b0;
    case (state_q)
      tss_pkg::S_IDLE: begin
        if (accept) begin
          st_d = tss_pkg::ST_OK; wo_d = '0; en_d = '0; bi_d = '0;
          state_d = tss_pkg::S_OUT;
          case (req_type_i)
            tss_pkg::REQ_LOAD: begin
              if (count_q == CntBits'(TableDepth)) begin
                st_d = tss_pkg::ST_FULL;
              end else if (count_q != '0 && wavelength_in_i <= last_wl_q) begin
                st_d = tss_pkg::ST_ORDER;
              end else begin
                mem_we = 1'b1;
                total_d = wr_sum;
                last_wl_d = wavelength_in_i;
                bi_d = 8'(count_q);
                count_d = count_q + 1'b1;
              end
            end
            tss_pkg::REQ_CLEAR: begin
              count_d = '0; total_d = '0;
            end
            tss_pkg::REQ_DRAW: begin
              if (count_q == '0 || total_q == '0) begin
                st_d = tss_pkg::ST_EMPTY;
              end else begin
                target_d = prod[WB+RandomBits-1:RandomBits];
                u2_d = uniform_offset_i;
                lo_d = '0; hi_d = last_idx; phase_d = 1'b0;
                state_d = tss_pkg::S_SEARCH;
              end
            end
            default: ;
          endcase
        end
      end
      tss_pkg::S_SEARCH: begin
        // Find the first entry whose running sum exceeds the target.
        if (lo_q == hi_q) begin
          rd_addr = lo_q[IdxBits-1:0];
          phase_d = 1'b0;
          state_d = tss_pkg::S_READ;
        end else if (!phase_q) begin
          phase_d = 1'b1;
        end else begin
          phase_d = 1'b0;
          if (rw_rd_q > target_q) hi_d = mid;
          else lo_d = CntBits'(mid + 1'b1);
        end
      end
      tss_pkg::S_READ: begin
        // Fetch w, then the interpolation end point.
        rd_addr = phase_q ? nx_idx[IdxBits-1:0] : lo_q[IdxBits-1:0];
        if (!phase_q) begin
          phase_d = 1'b1;
        end else begin
          w_d = wl_rd_q;
          rd_addr = nx_idx[IdxBits-1:0];
          state_d = tss_pkg::S_ADJ;
          phase_d = 1'b0;
        end
      end
      tss_pkg::S_ADJ: begin
        rd_addr = nx_idx[IdxBits-1:0];
        if (!phase_q) begin
          phase_d = 1'b1;
        end else begin
          case (mode_q)
            tss_pkg::MODE_HIST: begin
              hx = (RandomBits+22)'({u2_q, 1'b0}) * (RandomBits+22)'(binw_q);
              hy = (RandomBits+22)'(binw_q) << RandomBits;
              if (hx >= hy) begin
                hd = (hx - hy) >> (RandomBits + 1);
                wsum = (WavelengthBits+1)'(w_q) + (WavelengthBits+1)'(hd);
                if (wsum[WavelengthBits] || hd[RandomBits+21:WavelengthBits] != '0)
                  w_d = '1;
                else
                  w_d = wsum[WavelengthBits-1:0];
              end else begin
                hdn = ((hy - hx) + ((RandomBits+22)'(1) << (RandomBits + 1)) -
                       (RandomBits+22)'(1)) >> (RandomBits + 1);
                if (hdn > (RandomBits+22)'(w_q)) w_d = '0;
                else w_d = WavelengthBits'((RandomBits+22)'(w_q) - hdn);
              end
            end
            tss_pkg::MODE_INTERP: begin
              diff = wl_rd_q - w_q;
              iprod = (WavelengthBits+RandomBits)'(diff) *
                      (WavelengthBits+RandomBits)'(u2_q);
              w_d = w_q + iprod[WavelengthBits+RandomBits-1:RandomBits];
            end
            default: ;
          endcase
          phase_d = 1'b0;
          state_d = tss_pkg::S_DIV;
        end
      end
      tss_pkg::S_DIV: begin
        if (!phase_q) begin
          div_start = 1'b1;
          phase_d = 1'b1;
          wo_d = w_q;
          bi_d = 8'(lo_q);
          if (w_q == '0) begin
            en_d = tss_pkg::EnergyConst;
            phase_d = 1'b0;
            state_d = tss_pkg::S_OUT;
          end
        end else if (div_done) begin
          en_d = div_quo;
          phase_d = 1'b0;
          state_d = tss_pkg::S_OUT;
        end
      end
      tss_pkg::S_OUT: begin
        if (!ov_q || !out_stall_i) begin
          ov_d = 1'b1;
          state_d = tss_pkg::S_IDLE;
        end
      end
      default: state_d = tss_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tss_pkg::S_IDLE;
      count_q <= '0;
      total_q <= '0;
      phase_q <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      total_q <= total_d;
      phase_q <= phase_d;
      ov_q    <= ov_d;
    end
  end

  // Result register: loaded only when the previous beat has left.
  logic [1:0]                ost_q;
  logic [WavelengthBits-1:0] owl_q;
  logic [26:0]               oen_q;
  logic [7:0]                obi_q;

  always_ff @(posedge clk_i) begin
    last_wl_q <= last_wl_d; lo_q <= lo_d; hi_q <= hi_d; target_q <= target_d;
    u2_q <= u2_d; w_q <= w_d; st_q <= st_d; wo_q <= wo_d; en_q <= en_d;
    bi_q <= bi_d;
    if (state_q == tss_pkg::S_OUT && (!ov_q || !out_stall_i)) begin
      ost_q <= st_q; owl_q <= wo_q; oen_q <= en_q; obi_q <= bi_q;
    end
  end

  tss_div_chain #(
    .WavelengthBits(WavelengthBits)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .wl_i   (w_q),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  assign out_valid_o      = ov_q;
  assign status_o         = ost_q;
  assign wavelength_out_o = owl_q;
  assign energy_out_o     = oen_q;
  assign bin_index_o      = obi_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntBits'(TableDepth)) else $error("entry count beyond depth");
  a_one_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != tss_pkg::S_IDLE) else $error("accepted item lost");
  a_empty_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == '0 |-> total_q == '0) else $error("weight without entries");
  a_search_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == tss_pkg::S_SEARCH |-> lo_q <= hi_q) else $error("search crossed");

endmodule

// ===== tb/tb_tabulated_spectrum_sampler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spectrum sampler testbench
// Drives load, draw, clear and no-op beats into the sampler and checks every
// result beat against a cycle-free predictor of the table and the sampling
// arithmetic. Register settings change between phases, and both sides of the
// stream channels idle at random in several patterns.
// ----------------------------------------------------------------------------
module tb_tabulated_spectrum_sampler;

  localparam int unsigned Depth = 256;
  localparam longint unsigned WlMask = 64'hFFFFF;
  localparam int unsigned CycleLimit = 1000000;

  // One result beat as the block presents it.
  typedef struct packed {
    logic [1:0]  st;
    logic [19:0] wl;
    logic [26:0] en;
    logic [7:0]  idx;
  } sample_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  req_type_i = '0;
  logic [19:0] wavelength_in_i = '0;
  logic [15:0] weight_in_i = '0;
  logic [23:0] uniform_select_i = '0;
  logic [23:0] uniform_offset_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  status_o;
  logic [19:0] wavelength_out_o;
  logic [26:0] energy_out_o;
  logic [7:0]  bin_index_o;

  tabulated_spectrum_sampler u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .req_type_i       (req_type_i),
    .wavelength_in_i  (wavelength_in_i),
    .weight_in_i      (weight_in_i),
    .uniform_select_i (uniform_select_i),
    .uniform_offset_i (uniform_offset_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .wavelength_out_o (wavelength_out_o),
    .energy_out_o     (energy_out_o),
    .bin_index_o      (bin_index_o)
  );

  // 20 ns clock period.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow copy of the table and the registers, advanced once per accepted
  // input beat.
  int unsigned     tbl_count;
  longint unsigned tbl_cum [Depth];
  longint unsigned tbl_wl [Depth];
  longint unsigned tbl_total;
  logic [1:0]      cfg_mode;
  logic [19:0]     cfg_bin_width;

  sample_t pending_samples[$];
  int          errors = 0;
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  longint unsigned cycles = 0;

  // Works out the result of one request and updates the shadow table.
  function automatic sample_t draw_or_update(logic [1:0] req, logic [19:0] wl_in,
                                             logic [15:0] wt, logic [23:0] u1,
                                             logic [23:0] u2);
    sample_t r;
    longint unsigned sum, target, w, x, y, dn, diff;
    int unsigned i, last, nxt;
    r = '0;
    case (req)
      tss_pkg::REQ_LOAD: begin
        if (tbl_count >= Depth) begin
          r.st = tss_pkg::ST_FULL;
        end else if (tbl_count > 0 && wl_in <= tbl_wl[tbl_count-1]) begin
          r.st = tss_pkg::ST_ORDER;
        end else begin
          sum = tbl_total + wt;
          if (sum > 64'hFFFFFF) sum = 64'hFFFFFF;
          tbl_total = sum;
          tbl_cum[tbl_count] = sum;
          tbl_wl[tbl_count] = wl_in;
          r.st = tss_pkg::ST_OK;
          r.idx = tbl_count[7:0];
          tbl_count++;
        end
      end
      tss_pkg::REQ_CLEAR: begin
        tbl_count = 0;
        tbl_total = 0;
      end
      tss_pkg::REQ_NOP: begin
      end
      default: begin
        if (tbl_count == 0 || tbl_total == 0) begin
          r.st = tss_pkg::ST_EMPTY;
        end else begin
          target = (longint'(u1) * tbl_total) >> 24;
          last = tbl_count - 1;
          i = 0;
          while (i < last && tbl_cum[i] <= target) i++;
          w = tbl_wl[i];
          if (cfg_mode == tss_pkg::MODE_HIST) begin
            // Jitter of (u2 - 1/2) * bin_width, rounded toward minus infinity.
            x = 2 * longint'(u2) * cfg_bin_width;
            y = (64'd1 << 24) * cfg_bin_width;
            if (x >= y) begin
              w += (x - y) >> 25;
            end else begin
              dn = ((y - x) + (64'd1 << 25) - 1) >> 25;
              w = (dn > w) ? 0 : w - dn;
            end
            if (w > WlMask) w = WlMask;
          end else if (cfg_mode == tss_pkg::MODE_INTERP) begin
            // The last entry is its own end point.
            nxt = (i < last) ? i + 1 : i;
            diff = tbl_wl[nxt] - w;
            w += (diff * u2) >> 24;
            if (w > WlMask) w = WlMask;
          end
          r.st = tss_pkg::ST_OK;
          r.wl = w[19:0];
          r.en = (w == 0) ? tss_pkg::EnergyConst : 27'(64'd123984187 / w);
          r.idx = i[7:0];
        end
      end
    endcase
    return r;
  endfunction

  // The receiver stalls at random with the current phase's probability.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // Compares every accepted result beat with the oldest prediction.
  always @(posedge clk_i) begin
    sample_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{status_o, wavelength_out_o, energy_out_o, bin_index_o};
      if (pending_samples.size() == 0) begin
        $display("%0t: result beat with nothing expected: %p", $time, got);
        errors++;
      end else begin
        want = pending_samples.pop_front();
        if (got.st !== want.st) begin
          $display("%0t: status expected %0d actual %0d", $time, want.st, got.st);
          errors++;
        end
        if (got.wl !== want.wl) begin
          $display("%0t: wavelength expected %0d actual %0d", $time, want.wl, got.wl);
          errors++;
        end
        if (got.en !== want.en) begin
          $display("%0t: energy expected %0d actual %0d", $time, want.en, got.en);
          errors++;
        end
        if (got.idx !== want.idx) begin
          $display("%0t: bin index expected %0d actual %0d", $time, want.idx, got.idx);
          errors++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tabulated_spectrum_sampler regression: fail");
      $finish;
    end
  end

  // Sends one beat: an optional random gap, then holds the payload until the
  // block takes it, and predicts its result at that edge.
  task automatic send_beat(logic [1:0] req, logic [19:0] wl, logic [15:0] wt,
                           logic [23:0] u1, logic [23:0] u2);
    @(negedge clk_i);
    if ($urandom_range(99) < gap_pct) begin
      in_valid_i = 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < gap_pct);
    end
    req_type_i = req;
    wavelength_in_i = wl;
    weight_in_i = wt;
    uniform_select_i = u1;
    uniform_offset_i = u2;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    pending_samples.push_back(draw_or_update(req, wl, wt, u1, u2));
  endtask

  // Waits until every predicted result has been seen, plus a short margin.
  task automatic drain;
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_samples.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    @(negedge clk_i);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = addr;
    pwdata = data;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Register writes happen only with the block idle.
  task automatic set_config(logic [1:0] mode, logic [19:0] bw);
    drain();
    apb_write(3'd0, {30'd0, mode});
    cfg_mode = mode;
    apb_write(3'd4, {12'd0, bw});
    cfg_bin_width = bw;
  endtask

  task automatic draw_beat;
    send_beat(tss_pkg::REQ_DRAW, 20'($urandom), 16'($urandom), 24'($urandom),
              24'($urandom));
  endtask

  // Edge cases: empty table, zero weights, order errors, extreme fields and
  // every sampling mode including the undefined mode three.
  task automatic test_directed;
    logic [1:0] m;
    send_beat(tss_pkg::REQ_DRAW, '0, '0, 24'hFFFFFF, 24'hFFFFFF);
    send_beat(tss_pkg::REQ_LOAD, 20'd0, 16'd0, '0, '0);
    send_beat(tss_pkg::REQ_DRAW, '0, '0, 24'h800000, '0);
    send_beat(tss_pkg::REQ_LOAD, 20'd0, 16'd5, '0, '0);
    send_beat(tss_pkg::REQ_LOAD, 20'd100, 16'hFFFF, '0, '0);
    send_beat(tss_pkg::REQ_LOAD, 20'd200, 16'd0, '0, '0);
    send_beat(tss_pkg::REQ_LOAD, 20'hFFFFF, 16'd1, '0, '0);
    send_beat(tss_pkg::REQ_LOAD, 20'hFFFFF, 16'd1, '0, '0);
    send_beat(tss_pkg::REQ_NOP, 20'hFFFFF, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF);
    for (int k = 0; k < 4; k++) begin
      m = 2'(k);
      set_config(m, (k == 1) ? 20'hFFFFF : 20'd300);
      send_beat(tss_pkg::REQ_DRAW, '0, '0, 24'd0, 24'd0);
      send_beat(tss_pkg::REQ_DRAW, '0, '0, 24'hFFFFFF, 24'hFFFFFF);
      send_beat(tss_pkg::REQ_DRAW, '0, '0, 24'h7FFFFF, 24'h800000);
    end
    send_beat(tss_pkg::REQ_CLEAR, 20'hFFFFF, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send_beat(tss_pkg::REQ_DRAW, '0, '0, 24'h123456, 24'h654321);
  endtask

  // Fills the table to capacity, then pushes loads past it and draws.
  task automatic test_table_full;
    send_beat(tss_pkg::REQ_CLEAR, '0, '0, '0, '0);
    for (int k = 0; k < Depth + 3; k++)
      send_beat(tss_pkg::REQ_LOAD, 20'(k * 4000 + $urandom_range(3000)),
                16'($urandom), '0, '0);
    repeat (8) draw_beat();
  endtask

  // One phase of random traffic: mostly clear, ascending loads and draws,
  // with some noise beats mixed in.
  task automatic test_random_phase(int unsigned beats);
    int unsigned sent, n, d;
    logic [19:0] wl;
    sent = 0;
    while (sent < beats) begin
      if ($urandom_range(9) < 8) begin
        send_beat(tss_pkg::REQ_CLEAR, 20'($urandom), 16'($urandom), 24'($urandom),
                  24'($urandom));
        n = $urandom_range(1, 12);
        wl = 20'($urandom_range(0, 20'hFFFFF - 13 * 50000));
        for (int k = 0; k < n; k++) begin
          send_beat(tss_pkg::REQ_LOAD, wl,
                    ($urandom_range(4) == 0) ? 16'd0 : 16'($urandom),
                    24'($urandom), 24'($urandom));
          wl = wl + 20'($urandom_range(1, 50000));
        end
        sent += n + 1;
        if ($urandom_range(4) == 0) begin
          send_beat(tss_pkg::REQ_LOAD, 20'($urandom), 16'($urandom), '0, '0);
          sent++;
        end
        d = $urandom_range(2, 10);
        for (int k = 0; k < d; k++) draw_beat();
        sent += d;
      end else begin
        send_beat(2'($urandom), 20'($urandom), 16'($urandom), 24'($urandom),
                  24'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    tbl_count = 0;
    tbl_total = 0;
    cfg_mode = tss_pkg::MODE_HIST;
    cfg_bin_width = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();

    // No idling.
    set_config(tss_pkg::MODE_FIXED, 20'd0);
    test_table_full();
    test_random_phase(120);

    // Sender idle most of the time.
    set_config(tss_pkg::MODE_HIST, 20'hFFFFF);
    gap_pct = 81;
    test_random_phase(210);

    // Pause until every result is in before going on.
    drain();
    test_random_phase(20);

    // Receiver stalling most of the time.
    set_config(tss_pkg::MODE_INTERP, 20'd1234);
    gap_pct = 0;
    stall_pct = 81;
    test_random_phase(200);

    // Both sides idle now and then.
    set_config(tss_pkg::MODE_HIST, 20'($urandom));
    gap_pct = 24;
    stall_pct = 24;
    test_random_phase(170);

    drain();
    repeat (60) @(posedge clk_i);
    if (errors == 0 && pending_samples.size() == 0)
      $display("tabulated_spectrum_sampler regression: pass");
    else
      $display("tabulated_spectrum_sampler regression: fail");
    $finish;
  end

endmodule
